FILE: rtl/core/pgcc_pkg.sv
// Shared constants and codes for the polygon grid cell counter.
package pgcc_pkg;

  localparam int MAX_VERTICES_DEF = 128;
  localparam int COORD_BITS_DEF   = 12;
  localparam int COUNT_W          = 25;
  localparam int OUT_TW           = 32;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_OVERFLOW = 1'b1;

endpackage

FILE: rtl/core/pgcc_ram.sv
// Simple dual-port memory: one write port, one read port with registered data.
module pgcc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

FILE: rtl/core/pgcc_div.sv
// Iterative restoring divider with floor rounding and a remainder-nonzero flag.
module pgcc_div #(
  parameter int NW = 26,
  parameter int DW = 13
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [NW-1:0] num,
  input  logic signed [DW-1:0] den,
  output logic                 done_r,
  output logic signed [NW-1:0] quot_r,
  output logic                 rem_nz_r
);
  import pgcc_pkg::*;

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_BUSY = 2'd1;
  localparam logic [1:0] D_FIX  = 2'd2;
  localparam int CW = $clog2(NW + 1);

  logic [1:0]    st_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] rem_r;
  logic [NW-1:0] quo_r;
  logic [DW-1:0] dmag_r;
  logic          neg_r;
  logic [DW:0]   sh;
  logic          ge;

  assign sh = {rem_r, quo_r[NW-1]};
  assign ge = (sh >= {1'b0, dmag_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= D_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        D_IDLE: begin
          if (start) begin
            quo_r  <= num[NW-1] ? NW'(-num) : num;
            dmag_r <= den[DW-1] ? DW'(-den) : den;
            neg_r  <= num[NW-1] ^ den[DW-1];
            rem_r  <= '0;
            cnt_r  <= CW'(NW);
            st_r   <= D_BUSY;
          end
        end
        D_BUSY: begin
          rem_r <= ge ? DW'(sh - {1'b0, dmag_r}) : sh[DW-1:0];
          quo_r <= {quo_r[NW-2:0], ge};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CW'(1)) begin
            st_r <= D_FIX;
          end
        end
        D_FIX: begin
          rem_nz_r <= (rem_r != '0);
          if (neg_r) begin
            quot_r <= $signed(-quo_r - NW'(rem_r != '0));
          end else begin
            quot_r <= $signed(quo_r);
          end
          done_r <= 1'b1;
          st_r   <= D_IDLE;
        end
        default: st_r <= D_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/polygon_grid_cell_count.sv
// Top level of the polygon grid cell counter: vertex load, strip scan, sort and sum.
//
// Usage: vertices stream in on the in_ channel, one request per cycle while
// in_tready is high; in_tlast marks the final vertex, and the polygon closes
// back to its first vertex. One result request then leaves on the out_ channel:
// the touched-cell count in out_tdata and the status in out_tuser (1 = the
// vertex store overflowed, count forced to 0).
// After the final vertex come a min/max sweep over the vertices, then, per
// unit strip, a read and edge check of every vertex, two serial divisions
// (one quotient bit per cycle) for each edge crossing the strip, an insertion
// sort over the strip's spans in the span memory and a step per span pair.
// Both memories have one read port, which sets the pace of every sweep.
// Throughput: one vertex per cycle while loading; in_tready stays low from the
// final vertex until the result is placed in the output register.
// A held result does not block loading of the next polygon; only a second
// result waits until the first is taken.
// Reset clears the vertex count, the overflow flag, the controller and the
// output valid; memory contents are not cleared.
module polygon_grid_cell_count #(
  parameter int MAX_VERTICES = pgcc_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = pgcc_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // vertex_x [COORD_BITS-1:0], vertex_y above it, zero pad
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]     in_tdata,
  input  logic                                  in_tlast,   // last_vertex
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [pgcc_pkg::OUT_TW-1:0]           out_tdata,  // cell_count [24:0], zero pad
  output logic                                  out_tuser   // status
);
  import pgcc_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int AW = $clog2(MAX_VERTICES);
  localparam int VW = $clog2(MAX_VERTICES + 1);
  localparam int DW = CB + 1;      // coordinate differences
  localparam int NW = 2 * DW;      // product fed to the divider
  localparam int SW = CB + 1;      // span bounds

  localparam logic [4:0] S_LOAD    = 5'd0;
  localparam logic [4:0] S_MM_RD   = 5'd1;
  localparam logic [4:0] S_MM_USE  = 5'd2;
  localparam logic [4:0] S_STRIP   = 5'd3;
  localparam logic [4:0] S_EV_RD   = 5'd4;
  localparam logic [4:0] S_EV_USE  = 5'd5;
  localparam logic [4:0] S_NEXT    = 5'd6;
  localparam logic [4:0] S_CHK     = 5'd7;
  localparam logic [4:0] S_MUL     = 5'd8;
  localparam logic [4:0] S_DIV_GO  = 5'd9;
  localparam logic [4:0] S_DIV_W   = 5'd10;
  localparam logic [4:0] S_SORT    = 5'd11;
  localparam logic [4:0] S_SK_RD   = 5'd12;
  localparam logic [4:0] S_SK_USE  = 5'd13;
  localparam logic [4:0] S_SP_RD   = 5'd14;
  localparam logic [4:0] S_SP_USE  = 5'd15;
  localparam logic [4:0] S_SP_INS  = 5'd16;
  localparam logic [4:0] S_PAIR    = 5'd17;
  localparam logic [4:0] S_PA_RD   = 5'd18;
  localparam logic [4:0] S_PA_USE  = 5'd19;
  localparam logic [4:0] S_PB_RD   = 5'd20;
  localparam logic [4:0] S_PB_USE  = 5'd21;
  localparam logic [4:0] S_DONE    = 5'd22;

  logic [4:0]           state_r;
  logic [VW-1:0]        vcount_r;
  logic                 ovf_r;
  logic                 st_ovf_r;
  logic                 in_acc;
  logic                 room;

  // vertex memory
  logic                 vtx_we;
  logic [AW-1:0]        vtx_raddr;
  logic [2*CB-1:0]      vtx_rdata;
  logic signed [CB-1:0] rd_x, rd_y;

  // span memory
  logic                 spn_we;
  logic [AW-1:0]        spn_waddr, spn_raddr;
  logic [2*SW-1:0]      spn_wdata, spn_rdata;
  logic signed [SW-1:0] rd_l, rd_r;

  // scan state
  logic [AW-1:0]        idx_r;
  logic signed [CB-1:0] ymin_r, ymax_r;
  logic signed [CB:0]   y_r, yy_r;
  logic signed [CB-1:0] fx_r, fy_r, px_r, py_r;
  logic signed [CB-1:0] xa_r, ya_r, xb_r, yb_r;
  logic                 closing_r;
  logic                 phase_r;
  logic [VW-1:0]        k_r;
  logic signed [NW-1:0] prod_r;
  logic signed [DW-1:0] den_r;
  logic signed [SW-1:0] lo0_r, hi0_r;

  // sort and pair state
  logic [VW-1:0]        si_r, sj_r;
  logic signed [SW-1:0] key_l_r, key_r_r;
  logic [VW:0]          pi_r;
  logic signed [SW-1:0] start_r, prev_r;
  logic                 have_prev_r;
  logic [COUNT_W-1:0]   total_r;

  // divider
  logic                 div_start;
  logic                 div_done;
  logic signed [NW-1:0] div_q;
  logic                 div_rnz;

  // output register
  logic                 out_valid_r;
  logic [COUNT_W-1:0]   out_cnt_r;
  logic                 out_st_r;

  logic signed [DW-1:0] ya_e, yb_e, xa_e, xb_e, yy_d, dx;
  logic signed [SW-1:0] lo_c, hi_c;
  logic                 skip_c, greater_c;
  logic signed [SW-1:0] st_c;
  logic signed [SW:0]   gain_c;
  logic                 out_free;

  assign in_tready = (state_r == S_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign room      = (vcount_r != VW'(MAX_VERTICES));
  assign vtx_we    = in_acc && room;
  assign out_free  = !out_valid_r || out_tready;

  assign rd_x = $signed(vtx_rdata[CB-1:0]);
  assign rd_y = $signed(vtx_rdata[2*CB-1:CB]);
  assign rd_l = $signed(spn_rdata[SW-1:0]);
  assign rd_r = $signed(spn_rdata[2*SW-1:SW]);

  assign ya_e = {ya_r[CB-1], ya_r};
  assign yb_e = {yb_r[CB-1], yb_r};
  assign xa_e = {xa_r[CB-1], xa_r};
  assign xb_e = {xb_r[CB-1], xb_r};
  assign yy_d = yy_r - ya_e;
  assign dx   = xb_e - xa_e;

  // drop edges that lie wholly below or wholly above the strip
  assign skip_c = (ya_e <= y_r && yb_e <= y_r) || (ya_e > y_r && yb_e > y_r);

  assign lo_c = xa_e + div_q[SW-1:0];
  assign hi_c = lo_c + SW'(div_rnz);

  assign greater_c = (rd_l > key_l_r) || (rd_l == key_l_r && rd_r > key_r_r);
  assign st_c      = (have_prev_r && prev_r > start_r) ? prev_r : start_r;
  assign gain_c    = {rd_r[SW-1], rd_r} - {st_c[SW-1], st_c};

  assign div_start = (state_r == S_DIV_GO);

  pgcc_ram #(.WIDTH(2*CB), .DEPTH(MAX_VERTICES)) u_vtx_ram (
    .clk     (clk),
    .we      (vtx_we),
    .waddr   (vcount_r[AW-1:0]),
    .wdata   (in_tdata[2*CB-1:0]),
    .raddr   (vtx_raddr),
    .rdata_r (vtx_rdata)
  );

  pgcc_ram #(.WIDTH(2*SW), .DEPTH(MAX_VERTICES)) u_span_ram (
    .clk     (clk),
    .we      (spn_we),
    .waddr   (spn_waddr),
    .wdata   (spn_wdata),
    .raddr   (spn_raddr),
    .rdata_r (spn_rdata)
  );

  pgcc_div #(.NW(NW), .DW(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .num      (prod_r),
    .den      (den_r),
    .done_r   (div_done),
    .quot_r   (div_q),
    .rem_nz_r (div_rnz)
  );

  assign vtx_raddr = idx_r;

  // span memory port selection
  always_comb begin
    spn_we    = 1'b0;
    spn_waddr = sj_r[AW-1:0];
    spn_wdata = {key_r_r, key_l_r};
    spn_raddr = si_r[AW-1:0];
    case (state_r)
      S_DIV_W: begin
        spn_we    = div_done && phase_r;
        spn_waddr = k_r[AW-1:0];
        spn_wdata = {((hi0_r > hi_c) ? hi0_r : hi_c), ((lo0_r < lo_c) ? lo0_r : lo_c)};
      end
      S_SP_RD:  spn_raddr = AW'(sj_r - 1'b1);
      S_SP_USE: begin
        spn_we = 1'b1;
        if (greater_c) begin
          spn_wdata = {rd_r, rd_l};
        end
      end
      S_SP_INS: spn_we = 1'b1;
      S_PA_RD:  spn_raddr = pi_r[AW-1:0];
      S_PB_RD:  spn_raddr = AW'(pi_r + 1'b1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      vcount_r    <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            if (room) begin
              vcount_r <= vcount_r + 1'b1;
            end
            if (in_tlast) begin
              total_r <= '0;
              idx_r   <= '0;
              if (ovf_r || !room) begin
                st_ovf_r <= 1'b1;
                state_r  <= S_DONE;
              end else begin
                st_ovf_r <= 1'b0;
                state_r  <= S_MM_RD;
              end
            end else if (!room) begin
              ovf_r <= 1'b1;
            end
          end
        end
        S_MM_RD: state_r <= S_MM_USE;
        S_MM_USE: begin
          if (idx_r == '0 || rd_y < ymin_r) begin
            ymin_r <= rd_y;
          end
          if (idx_r == '0 || rd_y > ymax_r) begin
            ymax_r <= rd_y;
          end
          if (VW'(idx_r) == vcount_r - 1'b1) begin
            y_r     <= {(idx_r == '0 || rd_y < ymin_r) ? rd_y[CB-1] : ymin_r[CB-1],
                        (idx_r == '0 || rd_y < ymin_r) ? rd_y : ymin_r};
            state_r <= S_STRIP;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_MM_RD;
          end
        end
        S_STRIP: begin
          if (y_r >= $signed({ymax_r[CB-1], ymax_r})) begin
            state_r <= S_DONE;
          end else begin
            k_r       <= '0;
            idx_r     <= '0;
            closing_r <= 1'b0;
            state_r   <= S_EV_RD;
          end
        end
        S_EV_RD: state_r <= S_EV_USE;
        S_EV_USE: begin
          px_r <= rd_x;
          py_r <= rd_y;
          if (idx_r == '0) begin
            fx_r    <= rd_x;
            fy_r    <= rd_y;
            state_r <= S_NEXT;
          end else begin
            xa_r    <= px_r;
            ya_r    <= py_r;
            xb_r    <= rd_x;
            yb_r    <= rd_y;
            state_r <= S_CHK;
          end
        end
        S_NEXT: begin
          if (closing_r) begin
            si_r    <= VW'(1);
            state_r <= S_SORT;
          end else if (VW'(idx_r) == vcount_r - 1'b1) begin
            // closing edge back to the first vertex
            xa_r      <= px_r;
            ya_r      <= py_r;
            xb_r      <= fx_r;
            yb_r      <= fy_r;
            closing_r <= 1'b1;
            state_r   <= S_CHK;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_EV_RD;
          end
        end
        S_CHK: begin
          if (skip_c) begin
            state_r <= S_NEXT;
          end else begin
            phase_r <= 1'b0;
            yy_r    <= y_r;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= NW'(yy_d) * NW'(dx);
          den_r   <= yb_e - ya_e;
          state_r <= S_DIV_GO;
        end
        S_DIV_GO: state_r <= S_DIV_W;
        S_DIV_W: begin
          if (div_done) begin
            if (!phase_r) begin
              lo0_r   <= lo_c;
              hi0_r   <= hi_c;
              phase_r <= 1'b1;
              yy_r    <= y_r + 1'b1;
              state_r <= S_MUL;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_NEXT;
            end
          end
        end
        S_SORT: begin
          if (si_r >= k_r) begin
            pi_r        <= '0;
            have_prev_r <= 1'b0;
            state_r     <= S_PAIR;
          end else begin
            state_r <= S_SK_RD;
          end
        end
        S_SK_RD: state_r <= S_SK_USE;
        S_SK_USE: begin
          key_l_r <= rd_l;
          key_r_r <= rd_r;
          sj_r    <= si_r;
          state_r <= S_SP_RD;
        end
        S_SP_RD: state_r <= S_SP_USE;
        S_SP_USE: begin
          // shift the larger span up, or drop the key in place
          if (greater_c) begin
            sj_r    <= sj_r - 1'b1;
            state_r <= (sj_r == VW'(1)) ? S_SP_INS : S_SP_RD;
          end else begin
            si_r    <= si_r + 1'b1;
            state_r <= S_SORT;
          end
        end
        S_SP_INS: begin
          si_r    <= si_r + 1'b1;
          state_r <= S_SORT;
        end
        S_PAIR: begin
          if (pi_r + 1'b1 < {1'b0, k_r}) begin
            state_r <= S_PA_RD;
          end else begin
            y_r     <= y_r + 1'b1;
            state_r <= S_STRIP;
          end
        end
        S_PA_RD: state_r <= S_PA_USE;
        S_PA_USE: begin
          start_r <= rd_l;
          state_r <= S_PB_RD;
        end
        S_PB_RD: state_r <= S_PB_USE;
        S_PB_USE: begin
          if (rd_r > st_c) begin
            total_r <= total_r + {{(COUNT_W-SW-1){1'b0}}, gain_c};
          end
          if (!have_prev_r || rd_r > prev_r) begin
            prev_r <= rd_r;
          end
          have_prev_r <= 1'b1;
          pi_r        <= pi_r + 2'd2;
          state_r     <= S_PAIR;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_cnt_r   <= st_ovf_r ? '0 : total_r;
            out_st_r    <= st_ovf_r ? STATUS_OVERFLOW : STATUS_OK;
            vcount_r    <= '0;
            ovf_r       <= 1'b0;
            state_r     <= S_LOAD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TW-COUNT_W){1'b0}}, out_cnt_r};
  assign out_tuser  = out_st_r;

endmodule

FILE: rtl/core/pgcc_checker.sv
// Port-level checks for the polygon grid cell counter, bound to the top level.
module pgcc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic                       in_tlast,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [pgcc_pkg::OUT_TW-1:0] out_tdata,
  input logic                       out_tuser
);
  import pgcc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == STATUS_OVERFLOW |-> out_tdata == '0)
    else $error("overflow result carries a nonzero count");

  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input still open after final vertex");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind polygon_grid_cell_count pgcc_checker u_pgcc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
